// File: sv/tnrg_pkg.sv
// ----------------------------------------------------------------------------
// tnrg_pkg
// Shared types, constants and helper functions of the table noise generator:
// the 256-byte noise ROM, the byte-lane wrap offsets and the float encoding.
// ----------------------------------------------------------------------------
package tnrg_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_SEED_INDEX = 2'd0;
  localparam cfg_idx_t REG_SEED_ACCUM = 2'd1;

  // Kind of work a queued beat carries
  typedef enum logic {
    OP_DRAW    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  typedef struct packed {
    word_t index;
    word_t accum;
  } seed_t;

  // Per-lane offset and (modulus - offset) used when the lane goes negative
  localparam logic [7:0] LANE0_OFF  = 8'd28;
  localparam logic [7:0] LANE0_WRAP = 8'd216;   // 244 - 28
  localparam logic [7:0] LANE1_OFF  = 8'd24;
  localparam logic [7:0] LANE1_WRAP = 8'd212;   // 236 - 24
  localparam logic [7:0] LANE2_OFF  = 8'd12;
  localparam logic [7:0] LANE2_WRAP = 8'd200;   // 212 - 12
  localparam logic [7:0] LANE3_OFF  = 8'd4;
  localparam logic [7:0] LANE3_WRAP = 8'd184;   // 188 - 4

  localparam logic [23:0] FRAC_ONE = 24'h800000;
  localparam logic [7:0]  EXP_BIAS_LOW = 8'd104;  // 127 - 23

  localparam logic [7:0] NOISE_ROM [256] = '{
    8'h8E, 8'h14, 8'h27, 8'h99, 8'hFD, 8'hAA, 8'hC7, 8'h08, 8'hD5, 8'hE6,
    8'h3E, 8'h1F, 8'hF6, 8'hBB, 8'h55, 8'hDA, 8'h75, 8'hA0, 8'h4A, 8'h6A,
    8'hE8, 8'hBD, 8'h97, 8'hFF, 8'hDE, 8'h9B, 8'hBC, 8'h9F, 8'h81, 8'h8A,
    8'hA1, 8'h46, 8'h6E, 8'h0B, 8'hE3, 8'h63, 8'h76, 8'h7A, 8'h6C, 8'h5D,
    8'h88, 8'hD3, 8'h69, 8'hCA, 8'hC3, 8'h47, 8'hB9, 8'h25, 8'h83, 8'hAB,
    8'hA2, 8'h3F, 8'hA6, 8'h41, 8'h7C, 8'hBA, 8'hE5, 8'hAC, 8'h95, 8'h01,
    8'h7E, 8'hCF, 8'h09, 8'hC1, 8'hD9, 8'h62, 8'h70, 8'h71, 8'h8D, 8'hDB,
    8'h05, 8'h02, 8'h24, 8'h87, 8'hEF, 8'h54, 8'hC6, 8'hD4, 8'h37, 8'h30,
    8'hD0, 8'h1B, 8'hCB, 8'h7B, 8'hB8, 8'hE4, 8'hD8, 8'hEC, 8'h49, 8'hCE,
    8'hAD, 8'hDC, 8'h13, 8'hA9, 8'h94, 8'hC4, 8'h8F, 8'h39, 8'hAE, 8'h0D,
    8'h18, 8'h52, 8'hDD, 8'h0E, 8'h78, 8'hFA, 8'hF5, 8'h85, 8'h58, 8'hD2,
    8'hAF, 8'h6D, 8'hA4, 8'hB2, 8'h53, 8'h3B, 8'h51, 8'hA5, 8'h50, 8'hBE,
    8'hFC, 8'h2D, 8'hF4, 8'h11, 8'h48, 8'h98, 8'h16, 8'hF1, 8'h86, 8'hDF,
    8'h3D, 8'h66, 8'h5E, 8'h44, 8'h2E, 8'h2F, 8'h36, 8'h07, 8'h6B, 8'h17,
    8'h8B, 8'h29, 8'h4C, 8'hB6, 8'hE2, 8'h89, 8'h5F, 8'hE7, 8'hCD, 8'hA7,
    8'h21, 8'hE1, 8'h4D, 8'hC9, 8'h65, 8'hED, 8'hFE, 8'hEE, 8'h9C, 8'h23,
    8'h33, 8'h7D, 8'hB7, 8'h04, 8'h9E, 8'h9A, 8'h2A, 8'h40, 8'hB3, 8'h10,
    8'h5B, 8'hF3, 8'h82, 8'h77, 8'h1C, 8'h92, 8'h20, 8'h4E, 8'h1E, 8'h57,
    8'h22, 8'h72, 8'h06, 8'h8C, 8'h67, 8'h2C, 8'h73, 8'hFB, 8'h59, 8'hC2,
    8'h0A, 8'hBF, 8'h79, 8'h5C, 8'hF9, 8'h0C, 8'h28, 8'h1A, 8'h12, 8'h68,
    8'h74, 8'h34, 8'h19, 8'h42, 8'hB1, 8'hC0, 8'h84, 8'hF8, 8'h38, 8'hF0,
    8'h15, 8'h9D, 8'h60, 8'hF2, 8'h3A, 8'h6F, 8'hB4, 8'h90, 8'hEB, 8'h91,
    8'h1D, 8'h7F, 8'h35, 8'h61, 8'h5A, 8'h32, 8'h03, 8'h56, 8'hA3, 8'hC5,
    8'h2B, 8'h93, 8'h80, 8'h0F, 8'h4B, 8'h43, 8'hF7, 8'hA8, 8'hE0, 8'h3C,
    8'h96, 8'hD1, 8'h64, 8'h26, 8'hD7, 8'h45, 8'hCC, 8'h4F, 8'hC8, 8'hB0,
    8'hE9, 8'hB5, 8'h00, 8'hD6, 8'h31, 8'hEA
  };

  // Little-endian word starting at a ROM byte address (wraps in 8 bits)
  function automatic word_t rom_word(input logic [7:0] addr);
    logic [7:0] a1, a2, a3;
    a1 = addr + 8'd1;
    a2 = addr + 8'd2;
    a3 = addr + 8'd3;
    return {NOISE_ROM[a3], NOISE_ROM[a2], NOISE_ROM[a1], NOISE_ROM[addr]};
  endfunction

  function automatic logic [7:0] wrap_sub(input logic [7:0] b, input logic [7:0] off,
                                          input logic [7:0] wrap);
    return (b >= off) ? (b - off) : (b + wrap);
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // IEEE single bits of k / 2^23, exact for 0 <= k <= 2^23
  function automatic word_t frac_bits(input logic [23:0] k);
    logic [4:0]  p;
    logic [23:0] sh;
    word_t       res;
    p = '0;
    for (int i = 0; i < 24; i++) begin
      if (k[i]) begin
        p = i[4:0];
      end
    end
    sh = k << (5'd23 - p);
    if (k == '0) begin
      res = '0;
    end else begin
      res = {1'b0, {3'b000, p} + EXP_BIAS_LOW, sh[22:0]};
    end
    return res;
  endfunction

endpackage

// File: sv/tnrg_if.sv
// ----------------------------------------------------------------------------
// tnrg_if
// Valid/ready channel interfaces of the table noise generator: draw requests,
// results and configuration writes.
// ----------------------------------------------------------------------------
interface tnrg_draw_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface tnrg_result_if;
  logic                   valid;
  logic                   ready;
  logic [tnrg_pkg::WORD_W-1:0] raw_word;
  logic [tnrg_pkg::WORD_W-1:0] signed_uniform_bits;
  logic [tnrg_pkg::WORD_W-1:0] positive_uniform_bits;

  modport source (output valid, output raw_word, output signed_uniform_bits,
                  output positive_uniform_bits, input ready);
  modport sink (input valid, input raw_word, input signed_uniform_bits,
                input positive_uniform_bits, output ready);
endinterface

interface tnrg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tnrg_pkg::CFG_IDX_W-1:0] index;
  logic [tnrg_pkg::WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/tnrg_front.sv
// ----------------------------------------------------------------------------
// tnrg_front
// Accepts draw beats, tags them as plain draws or restarts and pushes them
// into the work queue. Also holds the seed registers.
// ----------------------------------------------------------------------------
module tnrg_front (
  input  logic               clk,
  input  logic               rst,
  tnrg_draw_if.sink          draw,
  tnrg_cfg_if.sink           cfg,
  input  logic               q_full,
  output logic               q_push,
  output tnrg_pkg::op_t      q_op,
  output tnrg_pkg::seed_t    seeds
);
  import tnrg_pkg::*;

  seed_t seed_regs;

  assign draw.ready = !q_full;
  assign q_push     = draw.valid && !q_full;
  assign q_op       = draw.restart ? OP_RESTART : OP_DRAW;
  assign cfg.ready  = 1'b1;
  assign seeds      = seed_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SEED_INDEX: seed_regs.index <= cfg.data;
        REG_SEED_ACCUM: seed_regs.accum <= cfg.data;
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: sv/tnrg_queue.sv
// ----------------------------------------------------------------------------
// tnrg_queue
// Small FIFO of tagged draw beats between the front and back parts.
// ----------------------------------------------------------------------------
module tnrg_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tnrg_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tnrg_pkg::op_t  head_op
);
  import tnrg_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_op   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/tnrg_back.sv
// ----------------------------------------------------------------------------
// tnrg_back
// Runs queued draws: stage one updates index and accumulator from the noise
// ROM, stage two encodes the float patterns into the result register.
// ----------------------------------------------------------------------------
module tnrg_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  tnrg_pkg::op_t    q_op,
  output logic             q_pop,
  input  tnrg_pkg::seed_t  seeds,
  tnrg_result_if.source    result
);
  import tnrg_pkg::*;

  word_t      index_word;
  word_t      accum_word;
  word_t      u_word;
  logic       u_valid;

  word_t      idx_src;
  word_t      acc_src;
  logic [7:0] a0, a1, a2, a3;
  word_t      idx_next;
  word_t      u_next;
  logic       out_free;
  logic       u_adv;

  logic [22:0] m;
  logic [23:0] k;
  word_t       neg_bits;
  word_t       pos_bits;

  assign out_free = !result.valid || result.ready;
  assign u_adv    = u_valid && out_free;
  assign q_pop    = q_not_empty && (!u_valid || u_adv);

  always_comb begin
    idx_src  = (q_op == OP_RESTART) ? seeds.index : index_word;
    acc_src  = (q_op == OP_RESTART) ? seeds.accum : accum_word;
    a0       = wrap_sub(idx_src[7:0],   LANE0_OFF, LANE0_WRAP);
    a1       = wrap_sub(idx_src[15:8],  LANE1_OFF, LANE1_WRAP);
    a2       = wrap_sub(idx_src[23:16], LANE2_OFF, LANE2_WRAP);
    a3       = wrap_sub(idx_src[31:24], LANE3_OFF, LANE3_WRAP);
    idx_next = {a3, a2, a1, a0};
    u_next   = (acc_src + rom_word(a0)) ^ rotl(rom_word(a3), 1)
             ^ rotl(rom_word(a2), 2) ^ rotl(rom_word(a1), 3);
  end

  // Stage one: state recurrence
  always_ff @(posedge clk) begin
    if (rst) begin
      index_word <= '0;
      accum_word <= '0;
      u_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        index_word <= idx_next;
        accum_word <= u_next;
        u_word     <= u_next;
      end
      if (q_pop) begin
        u_valid <= 1'b1;
      end else if (u_adv) begin
        u_valid <= 1'b0;
      end
    end
  end

  assign m        = u_word[22:0];
  assign k        = FRAC_ONE - {1'b0, m};
  assign neg_bits = frac_bits(k);
  assign pos_bits = frac_bits({1'b0, m});

  // Stage two: float encoding into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= u_valid;
      if (u_valid) begin
        result.raw_word              <= u_word;
        result.signed_uniform_bits   <= {~u_word[31], neg_bits[30:0]};
        result.positive_uniform_bits <= pos_bits;
      end
    end
  end

endmodule

// File: sv/table_noise_random_generator_unit.sv
// ----------------------------------------------------------------------------
// table_noise_random_generator_unit
// Pseudo-random generator over a fixed 256-byte noise ROM with float outputs.
// ----------------------------------------------------------------------------
// Each accepted draw beat yields one result beat carrying the new 32-bit
// accumulator and two IEEE single patterns made from it: a signed value in
// [-1,0) or (0,1] and a positive value in [0,1). A draw with restart set first
// reloads the index and accumulator from the seed registers, which only take
// effect at the next restart. Throughput is one draw per clock while the
// result channel is ready; a draw goes through the queue write on the
// accepting edge, the ROM and accumulator stage and the float encoding stage,
// in that order, before its result beat is presented. Up to QUEUE_DEPTH + 2
// draws may be in flight before the draw channel deasserts ready. The rate is
// set by the registered index/accumulator recurrence through the ROM.
module table_noise_random_generator_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  tnrg_draw_if.sink     draw,
  tnrg_cfg_if.sink      cfg,
  tnrg_result_if.source result
);
  import tnrg_pkg::*;

  logic  q_full;
  logic  q_push;
  op_t   q_push_op;
  logic  q_pop;
  logic  q_not_empty;
  op_t   q_head_op;
  seed_t seeds;

  tnrg_front u_front (
    .clk    (clk),
    .rst    (rst),
    .draw   (draw),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (q_push_op),
    .seeds  (seeds)
  );

  tnrg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (q_push_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (q_head_op)
  );

  tnrg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_op        (q_head_op),
    .q_pop       (q_pop),
    .seeds       (seeds),
    .result      (result)
  );

endmodule

// File: sv/tnrg_checker.sv
// ----------------------------------------------------------------------------
// tnrg_checker
// Port-level checks of the table noise generator, bound to the top level.
// ----------------------------------------------------------------------------
module tnrg_checker #(
  parameter int unsigned MAX_INFLIGHT = 4
) (
  input logic        clk,
  input logic        rst,
  input logic        draw_valid,
  input logic        draw_ready,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_raw
);

  localparam int unsigned CNT_W = $clog2(MAX_INFLIGHT + 2);

  logic [CNT_W-1:0] inflight;
  logic             draw_beat;
  logic             res_beat;

  assign draw_beat = draw_valid && draw_ready;
  assign res_beat  = res_valid && res_ready;

  // Track draws accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({draw_beat, res_beat})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (inflight != '0))
    else $error("result shown with no draw outstanding");

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    (inflight >= CNT_W'(MAX_INFLIGHT)) |-> !draw_ready)
    else $error("draw accepted beyond pipeline capacity");

  a_cfg_always_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_raw)))
    else $error("stalled result changed");

endmodule

bind table_noise_random_generator_unit tnrg_checker #(
  .MAX_INFLIGHT (QUEUE_DEPTH + 2)
) u_tnrg_checker (
  .clk        (clk),
  .rst        (rst),
  .draw_valid (draw.valid),
  .draw_ready (draw.ready),
  .cfg_valid  (cfg.valid),
  .cfg_ready  (cfg.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_raw    (result.raw_word)
);
